// ----- rtl/lkvc_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by every module of the block.
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int DATA_W  = 32;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  // classified operation passed from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic              hit;
    logic [IDX_W-1:0]  idx;
  } op_t;

  // command queue status
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] value;
  } result_t;

  typedef logic [ENTRIES-1:0][DATA_W-1:0] key_vec_t;
  typedef logic [ENTRIES-1:0]             valid_vec_t;

endpackage

// ----- rtl/lkvc_front.sv -----
// Front end: takes input transactions and classifies them against the tag store.
// Depends on lkvc_pkg; feeds lkvc_cmdq, reads keys and valid bits from lkvc_back.
module lkvc_front import lkvc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [0:0]               in_command,
  input  logic signed [DATA_W-1:0] in_lookup_key,
  input  logic signed [DATA_W-1:0] in_store_value,
  input  key_vec_t                 entry_keys,
  input  valid_vec_t               entry_valid,
  input  qstat_t                   q_stat,
  output logic                     q_push,
  output op_t                      q_op
);

  logic              hold_r, hold_nxt;
  cmd_t              cmd_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] value_r;
  logic              accept;
  logic              classify;
  valid_vec_t        match;
  logic [IDX_W-1:0]  match_idx;

  // classify only once every earlier update has been written back
  assign classify = hold_r && q_stat.empty;
  assign in_full  = hold_r && !classify;
  assign accept   = in_push && !in_full;
  assign hold_nxt = accept || (hold_r && !classify);

  // compare against every entry; keys held are unique, so OR the indices
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_keys[i] == key_r);
      if (match[i]) begin
        match_idx = match_idx | IDX_W'(i);
      end
    end
  end

  assign q_push    = classify;
  assign q_op.cmd  = cmd_r;
  assign q_op.key  = key_r;
  assign q_op.value = value_r;
  assign q_op.hit  = |match;
  assign q_op.idx  = match_idx;

  // hold the accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
    if (accept) begin
      cmd_r   <= cmd_t'(in_command);
      key_r   <= in_lookup_key;
      value_r <= in_store_value;
    end
  end

endmodule

// ----- rtl/lkvc_cmdq.sv -----
// Two-entry command queue between the front end and the back end.
// Depends on lkvc_pkg for the op_t and qstat_t types.
module lkvc_cmdq import lkvc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  op_t    push_op,
  input  logic   pop,
  output op_t    head_op,
  output qstat_t stat
);

  op_t        slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_op    = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // advance pointers and store the pushed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ----- rtl/lkvc_back.sv -----
// Back end: entry store, recency ranks, capacity register and result buffer.
// Depends on lkvc_pkg; pops classified operations from lkvc_cmdq.
module lkvc_back import lkvc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  qstat_t                   q_stat,
  input  op_t                      q_op,
  output logic                     q_pop,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_W-1:0]         cfg_data,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic                     out_hit,
  output logic signed [DATA_W-1:0] out_read_value,
  output key_vec_t                 entry_keys,
  output valid_vec_t               entry_valid
);

  logic [DATA_W-1:0] keys_r   [ENTRIES];
  logic [DATA_W-1:0] values_r [ENTRIES];
  logic [IDX_W-1:0]  rank_r   [ENTRIES];
  logic [IDX_W-1:0]  rank_nxt [ENTRIES];
  valid_vec_t        valid_r, valid_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0]  cap_r;

  logic [CMP_W-1:0]  cap_eff;
  logic              evict;
  valid_vec_t        old_oh;
  valid_vec_t        valid_after;
  logic [IDX_W-1:0]  free_slot;
  logic [IDX_W-1:0]  touch_rank;
  logic [IDX_W-1:0]  oldest_rank;
  logic              exec;
  logic              wr_en;
  logic              key_wr;
  logic [IDX_W-1:0]  wr_slot;

  result_t           obuf_r [2];
  logic              ob_wr_ptr_r, ob_rd_ptr_r;
  logic [1:0]        ob_cnt_r, ob_cnt_nxt;
  logic              ob_full;
  logic              ob_push, ob_pop;
  result_t           ob_in;

  assign cfg_ready = 1'b1;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_keys
    assign entry_keys[g] = keys_r[g];
  end
  assign entry_valid = valid_r;

  // execute when the head is ready and a get has room for its result
  assign ob_full = (ob_cnt_r == 2'd2);
  assign exec    = !q_stat.empty && ((q_op.cmd == CMD_PUT) || !ob_full);
  assign q_pop   = exec;

  // clamp capacity to one .. ENTRIES
  always_comb begin
    cap_eff = CMP_W'(cap_r);
    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end
  end

  // ranks form a permutation of 0 .. count-1, so the oldest holds count-1
  assign evict       = CMP_W'(count_r) >= cap_eff;
  assign oldest_rank = IDX_W'(count_r - 1'b1);
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      old_oh[i] = valid_r[i] && (rank_r[i] == oldest_rank);
    end
    valid_after = valid_r & ~(evict ? old_oh : '0);
  end

  // lowest free slot after any eviction
  always_comb begin
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_after[i]) begin
        free_slot = IDX_W'(i);
      end
    end
  end

  assign touch_rank = rank_r[q_op.idx];

  // next state of ranks, valid bits and occupancy
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    rank_nxt  = rank_r;
    wr_en     = 1'b0;
    key_wr    = 1'b0;
    wr_slot   = q_op.idx;
    if (exec) begin
      if (q_op.hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (IDX_W'(i) != q_op.idx) && (rank_r[i] < touch_rank)) begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end
        rank_nxt[q_op.idx] = '0;
        wr_en = (q_op.cmd == CMD_PUT);
      end else if (q_op.cmd == CMD_PUT) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_after[i]) begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end
        wr_slot            = free_slot;
        wr_en              = 1'b1;
        key_wr             = 1'b1;
        valid_nxt          = valid_after;
        valid_nxt[free_slot] = 1'b1;
        rank_nxt[free_slot]  = '0;
        count_nxt          = evict ? count_r : count_r + 1'b1;
      end
    end
  end

  // hold the store; write back on execute
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
    rank_r <= rank_nxt;
    if (wr_en) begin
      values_r[wr_slot] <= q_op.value;
    end
    if (key_wr) begin
      keys_r[wr_slot] <= q_op.key;
    end
  end

  // result buffer: two entries part the back end from the consumer
  assign ob_push      = exec && (q_op.cmd == CMD_GET);
  assign ob_pop       = out_pop && !out_empty;
  assign ob_in.hit    = q_op.hit;
  assign ob_in.value  = q_op.hit ? values_r[q_op.idx] : '0;
  assign out_empty    = (ob_cnt_r == 2'd0);
  assign out_hit      = obuf_r[ob_rd_ptr_r].hit;
  assign out_read_value = obuf_r[ob_rd_ptr_r].value;

  always_comb begin
    ob_cnt_nxt = ob_cnt_r;
    if (ob_push && !ob_pop) begin
      ob_cnt_nxt = ob_cnt_r + 2'd1;
    end else if (ob_pop && !ob_push) begin
      ob_cnt_nxt = ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_ptr_r <= 1'b0;
      ob_rd_ptr_r <= 1'b0;
      ob_cnt_r    <= 2'd0;
    end else begin
      ob_cnt_r <= ob_cnt_nxt;
      if (ob_push) begin
        ob_wr_ptr_r <= !ob_wr_ptr_r;
      end
      if (ob_pop) begin
        ob_rd_ptr_r <= !ob_rd_ptr_r;
      end
    end
    if (ob_push) begin
      obuf_r[ob_wr_ptr_r] <= ob_in;
    end
  end

  // occupancy tracks the valid bits
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("occupancy count disagrees with valid bits");

  // an eviction always finds exactly one oldest entry
  a_oldest_one: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (q_op.cmd == CMD_PUT) && !q_op.hit && evict) |-> $onehot(old_oh))
    else $error("eviction without a unique oldest entry");

  // a get result never lands in a full buffer
  a_ob_room: assert property (@(posedge clk) disable iff (!rst_n)
    ob_push |-> !ob_full)
    else $error("result pushed into full buffer");

  // occupancy does not grow at or above capacity
  a_cap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && evict) |=> (count_r == $past(count_r)))
    else $error("occupancy grew while at capacity");

endmodule

// ----- rtl/lru_key_value_cache_unit.sv -----
// Top level of the LRU key-value cache: front end, command queue, back end.
// Depends on lkvc_pkg, lkvc_front, lkvc_cmdq and lkvc_back.
//
// Fully associative key-value cache of ENTRIES (16) entries with LRU replacement.
// A transaction is taken into the front register and classified against all keys
// once the previous update has been written back, then passes through the command
// queue to the back end, which updates ranks, values and valid bits and, for a get,
// queues a result. The front register takes a new transaction as soon as the one it
// holds is classified, so classification and write-back over the entry store take
// turns. A get result is held back while the result side stalls. Puts give no
// result. The capacity register (reset 16, zero read as one, above 16 read as 16)
// may be written only while idle. No clearing pass is needed after reset.
module lru_key_value_cache_unit import lkvc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [0:0]               in_command,
  input  logic signed [DATA_W-1:0] in_lookup_key,
  input  logic signed [DATA_W-1:0] in_store_value,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic                     out_hit,
  output logic signed [DATA_W-1:0] out_read_value,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_W-1:0]         cfg_data
);

  key_vec_t   entry_keys;
  valid_vec_t entry_valid;
  qstat_t     q_stat;
  logic       q_push, q_pop;
  op_t        q_in_op, q_head_op;

  lkvc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_lookup_key  (in_lookup_key),
    .in_store_value (in_store_value),
    .entry_keys     (entry_keys),
    .entry_valid    (entry_valid),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_op           (q_in_op)
  );

  lkvc_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_in_op),
    .pop     (q_pop),
    .head_op (q_head_op),
    .stat    (q_stat)
  );

  lkvc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_op           (q_head_op),
    .q_pop          (q_pop),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .entry_keys     (entry_keys),
    .entry_valid    (entry_valid)
  );

endmodule

// ----- bench/lru_key_value_cache_unit_tb.sv -----
// Self-checking bench for the LRU key-value cache: a shadow copy of the cache
// predicts every get result, and random push/pop idling exercises the queues.
// Depends on lkvc_pkg and lru_key_value_cache_unit.

import lkvc_pkg::*;

// Shadow of the entry store; predicts get results and checks the replies.
class cache_shadow;
  logic [DATA_W-1:0] keys [ENTRIES];
  logic [DATA_W-1:0] vals [ENTRIES];
  bit                valid [ENTRIES];
  int                rank [ENTRIES];
  int                occupied;
  logic [CAP_W-1:0]  capacity;
  result_t           pending_reads [$];
  int                errors;
  int                lookups;
  int                hits;

  function new();
    foreach (valid[i]) begin
      valid[i] = 1'b0;
      rank[i]  = 0;
    end
    occupied = 0;
    capacity = CAP_RESET;
    errors   = 0;
    lookups  = 0;
    hits     = 0;
  endfunction

  // Make one entry the most recent; younger entries age by one.
  function void promote(int idx);
    int r;
    r = rank[idx];
    for (int i = 0; i < ENTRIES; i++)
      if (valid[i] && i != idx && rank[i] < r) rank[i]++;
    rank[idx] = 0;
  endfunction

  // Apply one accepted transaction and queue the expected reply of a get.
  function void note_request(cmd_t cmd, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
    int      idx;
    int      oldest;
    int      slot;
    int      limit;
    result_t r;
    idx = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (idx < 0 && valid[i] && keys[i] == key) idx = i;
    if (cmd == CMD_GET) begin
      lookups++;
      r.hit   = (idx >= 0);
      r.value = (idx >= 0) ? vals[idx] : '0;
      if (idx >= 0) begin
        hits++;
        promote(idx);
      end
      pending_reads.push_back(r);
    end else if (idx >= 0) begin
      vals[idx] = value;
      promote(idx);
    end else begin
      // clamp the capacity, then evict the oldest entry if at the limit
      limit = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : int'(capacity);
      if (occupied >= limit) begin
        oldest = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (valid[i] && (oldest < 0 || rank[i] > rank[oldest])) oldest = i;
        if (oldest >= 0) begin
          valid[oldest] = 1'b0;
          if (occupied > 0) occupied--;
        end
      end
      // take the lowest free slot; everyone else ages by one
      slot = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && !valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (valid[i]) rank[i]++;
        keys[slot]  = key;
        vals[slot]  = value;
        valid[slot] = 1'b1;
        rank[slot]  = 0;
        occupied++;
      end
    end
  endfunction

  // Compare one popped result with the oldest expectation.
  function void check_reply(logic hit, logic [DATA_W-1:0] value);
    result_t want;
    if (pending_reads.size() == 0) begin
      errors++;
      $display("%0t: result with none expected: hit=%0b value=%h", $time, hit, value);
      return;
    end
    want = pending_reads.pop_front();
    if (hit !== want.hit) begin
      errors++;
      $display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit, hit);
    end
    if (value !== want.value) begin
      errors++;
      $display("%0t: read_value mismatch: expected %h, actual %h",
               $time, want.value, value);
    end
  endfunction
endclass

module lru_key_value_cache_unit_tb;

  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 100;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_push;
  logic                     in_full;
  logic [0:0]               in_command;
  logic signed [DATA_W-1:0] in_lookup_key;
  logic signed [DATA_W-1:0] in_store_value;
  logic                     out_empty;
  logic                     out_pop;
  logic                     out_hit;
  logic signed [DATA_W-1:0] out_read_value;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         cfg_data;

  cache_shadow       shadow;
  bit                steady;
  int                requests;
  int                settings;
  logic [CAP_W-1:0]  phase_caps [11];
  logic [DATA_W-1:0] key_pool [20];

  lru_key_value_cache_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_lookup_key  (in_lookup_key),
    .in_store_value (in_store_value),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pop results, stalling at random outside the steady stretch.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) shadow.check_reply(out_hit, out_read_value);
    out_pop <= steady || ($urandom_range(0, 99) >= 20);
  end

  // Offer one transaction and hold it until the cache takes it.
  task automatic send_request(cmd_t cmd, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
    in_push        <= 1'b1;
    in_command     <= cmd;
    in_lookup_key  <= key;
    in_store_value <= value;
    do @(posedge clk); while (in_full);
    shadow.note_request(cmd, key, value);
    requests++;
  endtask

  // Drop push for a random gap now and then, outside the steady stretch.
  task automatic sender_gap();
    if (!steady && $urandom_range(0, 99) < 20) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Hold off until every expected result has been popped, then let puts settle.
  task automatic drain();
    in_push <= 1'b0;
    while (shadow.pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow.capacity = cap;
    settings++;
  endtask

  initial begin
    #4800000;
    $display("[lru_key_value_cache_unit] ERROR");
    $finish;
  end

  initial begin
    int pool_size;
    int eff;
    shadow   = new();
    steady   = 1'b0;
    requests = 0;
    settings = 0;
    phase_caps = '{5'd31, 5'd1, 5'd4, 5'd16, 5'd0, 5'd8, 5'd17, 5'd3, 5'd12, 5'd2, 5'd16};
    rst_n          <= 1'b0;
    in_push        <= 1'b0;
    in_command     <= CMD_GET;
    in_lookup_key  <= '0;
    in_store_value <= '0;
    out_pop        <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme keys and values, misses, updates, bit-exact compare
    send_request(CMD_GET, 32'h0000_0000, 32'hDEAD_BEEF);
    send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0001);
    send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(CMD_GET, 32'h7FFF_FFFE, 32'h0000_0000);
    send_request(CMD_GET, 32'h0000_0001, 32'h0000_0000);
    send_request(CMD_PUT, 32'h8000_0000, 32'h1234_5678);
    send_request(CMD_GET, 32'h8000_0000, 32'h5555_5555);
    send_request(CMD_GET, 32'hFFFF_FFFF, 32'hAAAA_AAAA);

    // Lower capacity below occupancy: each new key evicts exactly one entry
    drain();
    write_capacity(5'd2);
    send_request(CMD_PUT, 32'h5555_5555, 32'h0000_0055);
    send_request(CMD_PUT, 32'hAAAA_AAAA, 32'h0000_00AA);
    send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(CMD_GET, 32'h5555_5555, 32'h0000_0000);

    // Zero capacity behaves as one
    drain();
    write_capacity(5'd0);
    send_request(CMD_PUT, 32'h0000_0042, 32'h8000_0001);
    send_request(CMD_PUT, 32'h0000_0043, 32'h7FFF_FFFE);
    send_request(CMD_GET, 32'h0000_0042, 32'h0000_0000);
    send_request(CMD_GET, 32'h0000_0043, 32'h0000_0000);
    send_request(CMD_GET, 32'hAAAA_AAAA, 32'h0000_0000);

    // Random phases over a spread of capacity settings
    foreach (phase_caps[p]) begin
      drain();
      write_capacity(phase_caps[p]);
      steady = (p == 3);
      eff = (phase_caps[p] == 0) ? 1 : (phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p];
      pool_size = eff + 3;
      foreach (key_pool[k]) key_pool[k] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sender_gap();
        if ($urandom_range(0, 199) == 0) drain();
        send_request(cmd_t'($urandom_range(0, 1)),
                     ($urandom_range(0, 9) == 0) ? $urandom
                                                 : key_pool[$urandom_range(0, pool_size - 1)],
                     $urandom);
      end
    end
    steady = 1'b0;

    // Wait for the last results, then a short tail for stray output
    in_push <= 1'b0;
    while (shadow.pending_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d transactions over %0d capacity settings: %0d lookups, %0d hits.",
             requests, settings, shadow.lookups, shadow.hits);
    $display("Mismatches found: %0d", shadow.errors);
    if (shadow.errors == 0) begin
      $display("[lru_key_value_cache_unit] OK");
    end else begin
      $display("[lru_key_value_cache_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lkvc_pkg.sv
rtl/lkvc_front.sv
rtl/lkvc_cmdq.sv
rtl/lkvc_back.sv
rtl/lru_key_value_cache_unit.sv
bench/lru_key_value_cache_unit_tb.sv
